>>> rtl/xmcrc_pkg.sv
// shared constants, result type and crc step for the xmodem-crc block receiver
package xmcrc_pkg;

    // preamble and block size limits
    localparam int MAX_NAME_BYTES_DEF = 21;
    localparam int SMALL_BLOCK        = 128;
    localparam int LARGE_BLOCK        = 1024;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 5;
    localparam int INDEX_W = 11;
    localparam int CRC_W   = 16;

    // link control characters
    localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
    localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
    localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
    localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
    localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;
    localparam logic [BYTE_W-1:0] CH_C   = 8'h43;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

    typedef struct packed {
        logic              transfer_done;
        logic              keep_block;
        logic [KIND_W-1:0] out_kind;
        logic [BYTE_W-1:0] out_value;
    } result_t;

    // crc-16/xmodem over one byte, msb first
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/xmodem_crc_block_receiver.sv
// xmodem-crc receiver: preamble skip, block framing, crc check and verdict replies
// results are registered in the output stage before they reach the master side
// throughput: one byte per cycle while the skid entry is empty; the per-byte crc update
//   and framing counters are combinational, and a two-entry output stage (output register
//   plus skid) keeps the slave side open while one result waits
// reset: aresetn synchronous active low; returns to the name preamble with expected
//   block one and empties the output stage
module xmodem_crc_block_receiver #(
    parameter int MAX_NAME_BYTES = xmcrc_pkg::MAX_NAME_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [xmcrc_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [xmcrc_pkg::BYTE_W-1:0] m_axis_tdata,   // [7:0] out_value
    output logic [3:0]                   m_axis_tuser    // [1:0] out_kind, [2] keep_block,
                                                         // [3] transfer_done
);
    import xmcrc_pkg::*;

    typedef enum logic [2:0] {
        PH_NAME, PH_HEADER, PH_NUMBER, PH_INVERSE,
        PH_DATA, PH_CRC_HI, PH_CRC_LO, PH_HALTED
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] name_count_reg, name_count_next;
    logic               saw_cr_reg, saw_cr_next;
    logic               large_block_reg, large_block_next;
    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [BYTE_W-1:0]  expected_block_reg, expected_block_next;
    logic [BYTE_W-1:0]  block_number_reg, block_number_next;
    logic [BYTE_W-1:0]  block_inverse_reg, block_inverse_next;
    logic [CRC_W-1:0]   running_crc_reg, running_crc_next;
    logic [BYTE_W-1:0]  crc_high_reg, crc_high_next;

    result_t res;
    logic    res_valid;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic               acc, pop;
    logic [BYTE_W-1:0]  b;
    logic [COUNT_W-1:0] cnt;
    logic [INDEX_W-1:0] idx_inc;
    logic [INDEX_W-1:0] block_size;

    assign b     = s_axis_tdata;
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign pop   = out_valid_reg && m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;

    assign cnt        = (name_count_reg == '1) ? name_count_reg : name_count_reg + 1'b1;
    assign idx_inc    = byte_index_reg + 1'b1;
    assign block_size = large_block_reg ? INDEX_W'(LARGE_BLOCK) : INDEX_W'(SMALL_BLOCK);

    // per-byte protocol step
    always_comb begin
        phase_next          = phase_reg;
        name_count_next     = name_count_reg;
        saw_cr_next         = saw_cr_reg;
        large_block_next    = large_block_reg;
        byte_index_next     = byte_index_reg;
        expected_block_next = expected_block_reg;
        block_number_next   = block_number_reg;
        block_inverse_next  = block_inverse_reg;
        running_crc_next    = running_crc_reg;
        crc_high_next       = crc_high_reg;
        res_valid           = 1'b0;
        res                 = '0;
        case (phase_reg)
            PH_NAME: begin
                name_count_next = cnt;
                saw_cr_next     = (b == CH_CR);
                if (cnt > COUNT_W'(MAX_NAME_BYTES)) begin
                    phase_next   = PH_HALTED;
                    res_valid    = 1'b1;
                    res.out_kind = KIND_ABORT;
                end else if (saw_cr_reg && b == CH_LF) begin
                    phase_next      = PH_HEADER;
                    name_count_next = '0;
                    saw_cr_next     = 1'b0;
                    res_valid       = 1'b1;
                    res.out_kind    = KIND_REPLY;
                    res.out_value   = CH_C;
                end
            end
            PH_HEADER: begin
                if (b == CH_EOT) begin
                    phase_next        = PH_HALTED;
                    res_valid         = 1'b1;
                    res.out_kind      = KIND_REPLY;
                    res.out_value     = CH_ACK;
                    res.transfer_done = 1'b1;
                end else if (b == CH_SOH || b == CH_STX) begin
                    large_block_next = (b == CH_STX);
                    phase_next       = PH_NUMBER;
                end else begin
                    phase_next   = PH_HALTED;
                    res_valid    = 1'b1;
                    res.out_kind = KIND_ABORT;
                end
            end
            PH_NUMBER: begin
                block_number_next = b;
                phase_next        = PH_INVERSE;
            end
            PH_INVERSE: begin
                block_inverse_next = b;
                byte_index_next    = '0;
                running_crc_next   = '0;
                phase_next         = PH_DATA;
            end
            PH_DATA: begin
                running_crc_next = crc_step(running_crc_reg, b);
                byte_index_next  = idx_inc;
                if (idx_inc >= block_size) begin
                    byte_index_next = '0;
                    phase_next      = PH_CRC_HI;
                end
                res_valid     = 1'b1;
                res.out_kind  = KIND_DATA;
                res.out_value = b;
            end
            PH_CRC_HI: begin
                crc_high_next = b;
                phase_next    = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                res_valid = 1'b1;
                if (BYTE_W'(block_number_reg + block_inverse_reg) != 8'hFF) begin
                    phase_next   = PH_HALTED;
                    res.out_kind = KIND_ABORT;
                end else if (block_number_reg == BYTE_W'(expected_block_reg - 1'b1)) begin
                    // duplicate of the last good block
                    phase_next    = PH_HEADER;
                    res.out_kind  = KIND_REPLY;
                    res.out_value = CH_ACK;
                end else if (block_number_reg != expected_block_reg) begin
                    phase_next   = PH_HALTED;
                    res.out_kind = KIND_ABORT;
                end else if ({crc_high_reg, b} != running_crc_reg) begin
                    phase_next    = PH_HEADER;
                    res.out_kind  = KIND_REPLY;
                    res.out_value = CH_NAK;
                end else begin
                    phase_next          = PH_HEADER;
                    expected_block_next = expected_block_reg + 1'b1;
                    res.out_kind        = KIND_REPLY;
                    res.out_value       = CH_ACK;
                    res.keep_block      = 1'b1;
                end
            end
            PH_HALTED: begin
                res_valid = 1'b0;
            end
            default: begin
                phase_next = PH_HALTED;
            end
        endcase
    end

    // protocol state, updated per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_NAME;
            name_count_reg     <= '0;
            saw_cr_reg         <= 1'b0;
            large_block_reg    <= 1'b0;
            byte_index_reg     <= '0;
            expected_block_reg <= 8'd1;
            block_number_reg   <= '0;
            block_inverse_reg  <= '0;
            running_crc_reg    <= '0;
            crc_high_reg       <= '0;
        end else if (acc) begin
            phase_reg          <= phase_next;
            name_count_reg     <= name_count_next;
            saw_cr_reg         <= saw_cr_next;
            large_block_reg    <= large_block_next;
            byte_index_reg     <= byte_index_next;
            expected_block_reg <= expected_block_next;
            block_number_reg   <= block_number_next;
            block_inverse_reg  <= block_inverse_next;
            running_crc_reg    <= running_crc_next;
            crc_high_reg       <= crc_high_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (acc && res_valid) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.out_value;
    assign m_axis_tuser  = {out_reg.transfer_done, out_reg.keep_block, out_reg.out_kind};

    // a skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    // end of transfer is only flagged on an ack reply
    a_done_is_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[3]) |->
            (m_axis_tuser[1:0] == KIND_REPLY && m_axis_tdata == CH_ACK && !m_axis_tuser[2]))
        else $error("transfer done flagged on a non-ack result");

    // expected block only ever advances by one
    a_expected_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(expected_block_reg) |->
            expected_block_reg == BYTE_W'($past(expected_block_reg) + 1'b1))
        else $error("expected block number jumped");

endmodule
